[rtl/uyvy_yv12_pkg.sv]
package uyvy_yv12_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    localparam int CFG_W  = 13;
    localparam int ADDR_W = 25;
    localparam int COL_W  = 11;
    localparam int LINE_W = 12;
    localparam int IDX_W  = 2;

    typedef logic [CFG_W-1:0]  t_cfg;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_V = 2'd1,
        PLANE_U = 2'd2
    } t_plane;

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH   = 2'd0,
        REG_DST_WIDTH   = 2'd1,
        REG_COPY_HEIGHT = 2'd2
    } t_reg_idx;

    // effective (clamped) frame geometry
    typedef struct packed {
        t_cfg sw;
        t_cfg dw;
        t_cfg h;
    } t_dims;

    // one macropixel after position tracking
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] v;
        logic [7:0] u;
        t_addr      luma_addr;
        t_addr      chroma_off;
        logic       has_luma;
        logic       has_chroma;
    } t_work;

    function automatic t_cfg eff_width(input t_cfg v);
        t_cfg r;
        r = (v > t_cfg'(MAX_WIDTH)) ? t_cfg'(MAX_WIDTH) : v;
        r[0] = 1'b0;
        if (r < t_cfg'(2)) begin
            r = t_cfg'(2);
        end
        return r;
    endfunction

    function automatic t_cfg eff_height(input t_cfg v);
        t_cfg r;
        r = (v > t_cfg'(MAX_HEIGHT)) ? t_cfg'(MAX_HEIGHT) : v;
        if (r == '0) begin
            r = t_cfg'(1);
        end
        return r;
    endfunction

endpackage

[rtl/uyvy_yv12_base.sv]
module uyvy_yv12_base (
    input  logic                 i_clk,
    input  uyvy_yv12_pkg::t_dims i_dims,
    output uyvy_yv12_pkg::t_addr o_vbase,
    output uyvy_yv12_pkg::t_addr o_ubase
);

    logic [2*uyvy_yv12_pkg::CFG_W-1:0] prod_v;
    logic [2*uyvy_yv12_pkg::CFG_W-1:0] prod_c;
    uyvy_yv12_pkg::t_addr r_vbase;
    uyvy_yv12_pkg::t_addr r_cprod;
    uyvy_yv12_pkg::t_addr r_ubase;

    assign prod_v = i_dims.dw * i_dims.h;
    assign prod_c = (i_dims.dw >> 1) * (i_dims.h >> 1);

    // V base registered from width*height; U base registered from V base plus chroma size
    always_ff @(posedge i_clk) begin
        r_vbase <= prod_v[uyvy_yv12_pkg::ADDR_W-1:0];
        r_cprod <= prod_c[uyvy_yv12_pkg::ADDR_W-1:0];
        r_ubase <= r_vbase + r_cprod;
    end

    assign o_vbase = r_vbase;
    assign o_ubase = r_ubase;

endmodule

[rtl/uyvy_yv12_pos.sv]
module uyvy_yv12_pos (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_word,
    input  logic                 i_frame_start,
    input  uyvy_yv12_pkg::t_dims i_dims,
    output logic                 o_valid,
    input  logic                 i_ready,
    output uyvy_yv12_pkg::t_work o_work
);

    localparam int COL_W  = uyvy_yv12_pkg::COL_W;
    localparam int LINE_W = uyvy_yv12_pkg::LINE_W;
    localparam int CFG_W  = uyvy_yv12_pkg::CFG_W;

    logic        r_a_valid;
    logic [31:0] r_a_word;
    logic        r_a_fs;

    logic                 r_b_valid;
    uyvy_yv12_pkg::t_work r_b_work;

    logic [COL_W-1:0]     r_col;
    logic [LINE_W-1:0]    r_line;
    uyvy_yv12_pkg::t_addr r_lbase;
    uyvy_yv12_pkg::t_addr r_coff;
    logic                 r_done;

    logic [COL_W-1:0]     col;
    logic [LINE_W-1:0]    line;
    uyvy_yv12_pkg::t_addr lbase;
    uyvy_yv12_pkg::t_addr coff;
    logic                 done;

    logic [COL_W-1:0]     n_col;
    logic [LINE_W-1:0]    n_line;
    uyvy_yv12_pkg::t_addr n_lbase;
    uyvy_yv12_pkg::t_addr n_coff;
    logic                 n_done;

    uyvy_yv12_pkg::t_cfg  w;
    logic [COL_W:0]       x;
    logic [CFG_W-1:0]     line_ext;
    logic [CFG_W-1:0]     line_inc;
    logic [COL_W:0]       col_inc;
    logic                 end_line;
    logic                 active;
    uyvy_yv12_pkg::t_work work;

    logic b_take;
    logic a_move;

    assign b_take  = !r_b_valid || i_ready;
    assign a_move  = r_a_valid && b_take;
    assign o_ready = !r_a_valid || a_move;

    always_comb begin
        // frame start clears position before the item is used
        col   = r_a_fs ? '0 : r_col;
        line  = r_a_fs ? '0 : r_line;
        lbase = r_a_fs ? '0 : r_lbase;
        coff  = r_a_fs ? '0 : r_coff;
        done  = r_a_fs ? 1'b0 : r_done;

        w        = (i_dims.sw < i_dims.dw) ? i_dims.sw : i_dims.dw;
        x        = {col, 1'b0};
        line_ext = {1'b0, line};
        line_inc = line_ext + CFG_W'(1);
        active   = !done && (line_ext < i_dims.h);

        work.y0         = r_a_word[15:8];
        work.y1         = r_a_word[31:24];
        work.v          = r_a_word[23:16];
        work.u          = r_a_word[7:0];
        work.luma_addr  = lbase + uyvy_yv12_pkg::t_addr'(x);
        work.chroma_off = coff + uyvy_yv12_pkg::t_addr'(col);
        work.has_luma   = active && ({1'b0, x} < w);
        // chroma only on even lines that have a partner line inside the crop
        work.has_chroma = work.has_luma && !line[0] && (line_inc < i_dims.h);

        col_inc  = {1'b0, col} + (COL_W+1)'(1);
        end_line = col_inc >= i_dims.sw[CFG_W-1:1];

        n_col   = end_line ? '0 : col_inc[COL_W-1:0];
        n_line  = line;
        n_lbase = lbase;
        n_coff  = coff;
        n_done  = done;
        if (end_line && !done) begin
            n_lbase = lbase + uyvy_yv12_pkg::t_addr'(i_dims.dw);
            if (line[0]) begin
                n_coff = coff + uyvy_yv12_pkg::t_addr'(i_dims.dw >> 1);
            end
            n_line = line_inc[LINE_W-1:0];
            n_done = line_inc >= i_dims.h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_col     <= '0;
            r_line    <= '0;
            r_lbase   <= '0;
            r_coff    <= '0;
            r_done    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_take) begin
                r_b_valid <= r_a_valid;
            end
            if (a_move) begin
                r_col   <= n_col;
                r_line  <= n_line;
                r_lbase <= n_lbase;
                r_coff  <= n_coff;
                r_done  <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_word <= i_word;
            r_a_fs   <= i_frame_start;
        end
        if (a_move) begin
            r_b_work <= work;
        end
    end

    assign o_valid = r_b_valid;
    assign o_work  = r_b_work;

endmodule

[rtl/uyvy_yv12_emit.sv]
module uyvy_yv12_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  uyvy_yv12_pkg::t_work  i_work,
    input  uyvy_yv12_pkg::t_addr  i_vbase,
    input  uyvy_yv12_pkg::t_addr  i_ubase,
    output logic                  o_valid,
    input  logic                  i_ready,
    output uyvy_yv12_pkg::t_addr  o_addr,
    output logic [7:0]            o_value,
    output uyvy_yv12_pkg::t_plane o_plane,
    output logic                  o_last
);

    localparam int IDX_W = uyvy_yv12_pkg::IDX_W;

    logic             r_o_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_chroma;
    uyvy_yv12_pkg::t_addr r_a0;
    uyvy_yv12_pkg::t_addr r_a1;
    uyvy_yv12_pkg::t_addr r_av;
    uyvy_yv12_pkg::t_addr r_au;
    logic [7:0] r_y0;
    logic [7:0] r_y1;
    logic [7:0] r_v;
    logic [7:0] r_u;

    logic out_done;
    logic load;

    assign out_done = r_o_valid && i_ready && o_last;
    assign o_ready  = !r_o_valid || out_done;
    // items outside the crop are dropped here
    assign load     = i_valid && o_ready && i_work.has_luma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (load) begin
                r_o_valid <= 1'b1;
                r_idx     <= '0;
            end else begin
                if (out_done) begin
                    r_o_valid <= 1'b0;
                end
                if (r_o_valid && i_ready) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chroma <= i_work.has_chroma;
            r_a0     <= i_work.luma_addr;
            r_a1     <= i_work.luma_addr + uyvy_yv12_pkg::t_addr'(1);
            r_av     <= i_vbase + i_work.chroma_off;
            r_au     <= i_ubase + i_work.chroma_off;
            r_y0     <= i_work.y0;
            r_y1     <= i_work.y1;
            r_v      <= i_work.v;
            r_u      <= i_work.u;
        end
    end

    // result order: Y0, Y1, V, U
    always_comb begin
        case (r_idx)
            2'd0: begin
                o_addr  = r_a0;
                o_value = r_y0;
                o_plane = uyvy_yv12_pkg::PLANE_Y;
            end
            2'd1: begin
                o_addr  = r_a1;
                o_value = r_y1;
                o_plane = uyvy_yv12_pkg::PLANE_Y;
            end
            2'd2: begin
                o_addr  = r_av;
                o_value = r_v;
                o_plane = uyvy_yv12_pkg::PLANE_V;
            end
            default: begin
                o_addr  = r_au;
                o_value = r_u;
                o_plane = uyvy_yv12_pkg::PLANE_U;
            end
        endcase
        o_last = r_chroma ? (r_idx == IDX_W'(3)) : (r_idx == IDX_W'(1));
    end

    assign o_valid = r_o_valid;

endmodule

[rtl/uyvy_to_yv12_planar_writer.sv]
// Pipeline: a request passes the input, position and output registers in turn.
// Throughput: one request per cycle enters unless the pipeline stalls; the
// output gives one write per cycle while m_axis_tready is high, so a request in
// the crop makes 2 writes (luma only) or 4 (with chroma) and holds the input.
// Reset: synchronous, active low; clears position and pipeline valids and loads
// widths 1920/1920 and height 1080; plane bases are registered, U after V.
module uyvy_to_yv12_planar_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_word
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [24:0] byte_address, [32:25] byte_value, zeros
    output logic [1:0]  m_axis_tuser,   // [1:0] plane
    output logic        m_axis_tlast
);

    uyvy_yv12_pkg::t_cfg r_src_width;
    uyvy_yv12_pkg::t_cfg r_dst_width;
    uyvy_yv12_pkg::t_cfg r_copy_height;

    uyvy_yv12_pkg::t_dims  dims;
    uyvy_yv12_pkg::t_addr  vbase;
    uyvy_yv12_pkg::t_addr  ubase;
    uyvy_yv12_pkg::t_work  work;
    uyvy_yv12_pkg::t_addr  out_addr;
    uyvy_yv12_pkg::t_plane out_plane;
    logic [7:0] out_value;
    logic       work_valid;
    logic       work_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= uyvy_yv12_pkg::t_cfg'(1920);
            r_dst_width   <= uyvy_yv12_pkg::t_cfg'(1920);
            r_copy_height <= uyvy_yv12_pkg::t_cfg'(1080);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                uyvy_yv12_pkg::REG_SRC_WIDTH:   r_src_width   <= i_cfg_data;
                uyvy_yv12_pkg::REG_DST_WIDTH:   r_dst_width   <= i_cfg_data;
                uyvy_yv12_pkg::REG_COPY_HEIGHT: r_copy_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign dims.sw = uyvy_yv12_pkg::eff_width(r_src_width);
    assign dims.dw = uyvy_yv12_pkg::eff_width(r_dst_width);
    assign dims.h  = uyvy_yv12_pkg::eff_height(r_copy_height);

    uyvy_yv12_base u_base (
        .i_clk   (i_clk),
        .i_dims  (dims),
        .o_vbase (vbase),
        .o_ubase (ubase)
    );

    uyvy_yv12_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_word        (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_dims        (dims),
        .o_valid       (work_valid),
        .i_ready       (work_ready),
        .o_work        (work)
    );

    uyvy_yv12_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (work_valid),
        .o_ready (work_ready),
        .i_work  (work),
        .i_vbase (vbase),
        .i_ubase (ubase),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_addr  (out_addr),
        .o_value (out_value),
        .o_plane (out_plane),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_value, out_addr};
    assign m_axis_tuser = out_plane;

    // V write never ends a request
    a_v_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == uyvy_yv12_pkg::PLANE_V) |-> !m_axis_tlast)
        else $error("V write marked last");

    // U write always ends a request
    a_u_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == uyvy_yv12_pkg::PLANE_U) |-> m_axis_tlast)
        else $error("U write not marked last");

    // U follows V at once
    a_v_then_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == uyvy_yv12_pkg::PLANE_V)
        |=> (m_axis_tvalid && m_axis_tuser == uyvy_yv12_pkg::PLANE_U))
        else $error("V write not followed by U write");

endmodule
